// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared widths, status codes, sequencer states and a helper function.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int DEFAULT_TOTAL_UNITS = 64;

   localparam int REQ_SIZE_W  = 7;
   localparam int OFFSET_W    = 6;
   localparam int SIZE_W      = 7;
   localparam int STATUS_W    = 2;
   localparam int ORDER_REQ_W = 3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_ZERO    = 2'd2,
      ST_BADFREE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_DOWN,
      S_GRANT,
      S_UP,
      S_FIN
   } state_type;

   typedef struct packed {
      logic lfo_fits;
      logic ord_is_k;
      logic child_is_k;
      logic ord_is_zero;
      logic start_match;
      logic off_in_pool;
   } alu_flags_type;

   // Smallest k with 2**k >= req; meaningless for req == 0.
   function automatic logic [ORDER_REQ_W-1:0] ceil_log2_req(
      input logic [REQ_SIZE_W-1:0] req
   );
      logic [REQ_SIZE_W-1:0]  m;
      logic [ORDER_REQ_W-1:0] k;
      m = req - REQ_SIZE_W'(1);
      k = '0;
      for (int i = 0; i < REQ_SIZE_W; i++) begin
         if (m[i]) begin
            k = ORDER_REQ_W'(i + 1);
         end
      end
      return k;
   endfunction

endpackage

// ===== rtl/core/bba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bba_node_alu.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator node unit
// Per-level compare, child select, block start/size shift and buddy merge,
// reused by every tree-walk step of the sequencer.
// ----------------------------------------------------------------------------
module bba_node_alu
   import bba_pkg::*;
#(
   parameter int POOL_ORDER = 6,
   parameter int NODE_W     = 7,
   parameter int ORD_W      = 3,
   parameter int AW         = 7
) (
   input  logic [NODE_W-1:0] node,
   input  logic [ORD_W-1:0]  ord,
   input  logic [ORD_W-1:0]  k,
   input  logic [ORD_W-1:0]  lfo,
   input  logic [ORD_W-1:0]  cur,
   input  logic [AW-1:0]     off,
   output alu_flags_type     flags,
   output logic [AW-1:0]     start,
   output logic [AW-1:0]     size,
   output logic [ORD_W-1:0]  merged,
   output logic [NODE_W-1:0] alloc_child,
   output logic [NODE_W-1:0] free_child
);

   localparam logic [AW-1:0] POOL_SIZE = AW'(1) << POOL_ORDER;

   logic [AW-1:0]    node_ext;
   logic [AW-1:0]    off_shift;
   logic [ORD_W-1:0] pord;
   logic [ORD_W-1:0] left_lfo;
   logic [ORD_W-1:0] right_lfo;

   // The leading one of the node lands on bit POOL_ORDER; drop it.
   assign node_ext = AW'(node);
   assign start    = (node_ext << ord) & (POOL_SIZE - AW'(1));
   assign size     = AW'(1) << ord;

   assign off_shift   = off >> (ord - ORD_W'(1));
   assign alloc_child = (node << 1) | NODE_W'(!flags.lfo_fits);
   assign free_child  = (node << 1) | NODE_W'(off_shift[0]);

   // Parent summary from the node just written (cur) and its buddy (lfo).
   assign pord      = ord + ORD_W'(1);
   assign left_lfo  = node[0] ? lfo : cur;
   assign right_lfo = node[0] ? cur : lfo;

   always_comb begin
      if (left_lfo == pord && right_lfo == pord) begin
         merged = pord + ORD_W'(1);
      end else if (left_lfo > right_lfo) begin
         merged = left_lfo;
      end else begin
         merged = right_lfo;
      end
   end

   assign flags.lfo_fits    = lfo > k;
   assign flags.ord_is_k    = ord == k;
   assign flags.child_is_k  = ord == k + ORD_W'(1);
   assign flags.ord_is_zero = ord == '0;
   assign flags.start_match = start == off;
   assign flags.off_in_pool = off < POOL_SIZE;

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a power-of-two pool, tree summaries in RAM,
// one tree level per cycle through a shared node unit.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  request  | req_valid req_stall req_operation            | in
//           | req_request_size req_block_offset            |
//  response | rsp_valid rsp_stall rsp_status               | out
//           | rsp_granted_offset rsp_granted_size          |
//
// One beat at a time, with P = pool order. An allocate walks down from the root
// to a free block of the granted order and merges back up; a free walks down to
// its block, frees it and merges back up; an error ends the walk early. Each
// ends in idle before the next accept. Each step is one RAM read of a tree node.
// After reset a clearing pass writes all 2**(P+1) tree entries (128 at the
// default size) while req_stall stays high.
// A response beat waits in its register under rsp_stall; a new request is
// taken meanwhile and finishes once that register frees up.
// ----------------------------------------------------------------------------
module buddy_block_allocator
   import bba_pkg::*;
#(
   parameter int TOTAL_UNITS = DEFAULT_TOTAL_UNITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [REQ_SIZE_W-1:0] req_request_size,
   input  logic [OFFSET_W-1:0]   req_block_offset,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [OFFSET_W-1:0]   rsp_granted_offset,
   output logic [SIZE_W-1:0]     rsp_granted_size
);

   localparam int POOL_ORDER = $clog2(TOTAL_UNITS + 1) - 1;
   localparam int NODE_W     = POOL_ORDER + 1;
   localparam int ORD_W      = $clog2(POOL_ORDER + 2);
   localparam int AW         = (NODE_W > SIZE_W) ? NODE_W : SIZE_W;
   localparam int ENTRY_W    = ORD_W + 1;
   localparam int DEPTH      = 2 ** NODE_W;

   localparam logic [AW-1:0]     POOL_SIZE = AW'(1) << POOL_ORDER;
   localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);

   state_type           state_ff, state_in;
   logic [NODE_W-1:0]   clr_ff, clr_in;
   logic                op_ff, op_in;
   logic                zero_ff, zero_in;
   logic                over_ff, over_in;
   logic [ORD_W-1:0]    k_ff, k_in;
   logic [AW-1:0]       off_ff, off_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [ORD_W-1:0]    ord_ff, ord_in;
   logic [ORD_W-1:0]    cur_ff, cur_in;
   status_type          res_status_ff, res_status_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;
   logic [SIZE_W-1:0]   res_size_ff, res_size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic                ram_wr_en;
   logic [NODE_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [NODE_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic                rd_alloc;
   logic [ORD_W-1:0]    rd_lfo;

   alu_flags_type       flags;
   logic [AW-1:0]       alu_start;
   logic [AW-1:0]       alu_size;
   logic [ORD_W-1:0]    alu_merged;
   logic [NODE_W-1:0]   alloc_child;
   logic [NODE_W-1:0]   free_child;
   logic [NODE_W-1:0]   parent;

   logic [ORD_W-1:0]    clr_depth;
   logic [ORD_W-1:0]    clr_init;
   logic                out_free;

   assign rd_alloc = ram_rd_data[ORD_W];
   assign rd_lfo   = ram_rd_data[ORD_W-1:0];
   assign parent   = node_ff >> 1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   bba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bba_node_alu #(
      .POOL_ORDER (POOL_ORDER),
      .NODE_W     (NODE_W),
      .ORD_W      (ORD_W),
      .AW         (AW)
   ) u_node_alu (
      .node        (node_ff),
      .ord         (ord_ff),
      .k           (k_ff),
      .lfo         (rd_lfo),
      .cur         (cur_ff),
      .off         (off_ff),
      .flags       (flags),
      .start       (alu_start),
      .size        (alu_size),
      .merged      (alu_merged),
      .alloc_child (alloc_child),
      .free_child  (free_child)
   );

   // Reset value of a node: its own order plus one.
   always_comb begin
      clr_depth = '0;
      for (int i = 0; i < NODE_W; i++) begin
         if (clr_ff[i]) begin
            clr_depth = ORD_W'(i);
         end
      end
   end

   assign clr_init = ORD_W'(POOL_ORDER + 1) - clr_depth;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (op_ff == OP_ALLOC) begin
               if (zero_ff || over_ff || !flags.lfo_fits) begin
                  state_in = S_FIN;
               end else if (flags.ord_is_k) begin
                  state_in = S_GRANT;
               end else begin
                  state_in = S_DOWN;
               end
            end else begin
               if (rd_alloc) begin
                  state_in = (flags.start_match && node_ff != ROOT) ? S_UP : S_FIN;
               end else if (flags.ord_is_zero || !flags.off_in_pool) begin
                  state_in = S_FIN;
               end
            end
         end
         S_DOWN: begin
            if (flags.child_is_k) begin
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            state_in = (node_ff == ROOT) ? S_FIN : S_UP;
         end
         S_UP: begin
            if (parent == ROOT) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // RAM control and datapath
   always_comb begin
      ram_wr_en     = 1'b0;
      ram_wr_addr   = node_ff;
      ram_wr_data   = {1'b0, rd_lfo};
      ram_rd_addr   = node_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      zero_in       = zero_ff;
      over_in       = over_ff;
      k_in          = k_ff;
      off_in        = off_ff;
      node_in       = node_ff;
      ord_in        = ord_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_size_in   = rsp_size_ff;
      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = {1'b0, clr_init};
            clr_in      = clr_ff + NODE_W'(1);
         end
         S_IDLE: begin
            ram_rd_addr = ROOT;
            if (req_valid) begin
               op_in   = req_operation;
               zero_in = req_request_size == '0;
               over_in = AW'(req_request_size) > POOL_SIZE;
               k_in    = ORD_W'(ceil_log2_req(req_request_size));
               off_in  = AW'(req_block_offset);
               node_in = ROOT;
               ord_in  = ORD_W'(POOL_ORDER);
            end
         end
         S_EVAL: begin
            if (op_ff == OP_ALLOC) begin
               if (zero_ff) begin
                  res_status_in = ST_ZERO;
                  res_off_in    = '0;
                  res_size_in   = '0;
               end else if (over_ff || !flags.lfo_fits) begin
                  res_status_in = ST_NOSPACE;
                  res_off_in    = '0;
                  res_size_in   = '0;
               end else if (!flags.ord_is_k) begin
                  ram_rd_addr = node_ff << 1;
               end
            end else begin
               if (rd_alloc) begin
                  if (flags.start_match) begin
                     // release the block, then refresh its ancestors
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = {1'b0, ord_ff + ORD_W'(1)};
                     cur_in        = ord_ff + ORD_W'(1);
                     ram_rd_addr   = node_ff ^ NODE_W'(1);
                     res_status_in = ST_OK;
                     res_off_in    = alu_start[OFFSET_W-1:0];
                     res_size_in   = alu_size[SIZE_W-1:0];
                  end else begin
                     res_status_in = ST_BADFREE;
                     res_off_in    = '0;
                     res_size_in   = '0;
                  end
               end else if (flags.ord_is_zero || !flags.off_in_pool) begin
                  res_status_in = ST_BADFREE;
                  res_off_in    = '0;
                  res_size_in   = '0;
               end else begin
                  node_in     = free_child;
                  ord_in      = ord_ff - ORD_W'(1);
                  ram_rd_addr = free_child;
               end
            end
         end
         S_DOWN: begin
            // take the left child if it fits, else the right one
            node_in     = alloc_child;
            ord_in      = ord_ff - ORD_W'(1);
            ram_rd_addr = alloc_child << 1;
         end
         S_GRANT: begin
            ram_wr_en     = 1'b1;
            ram_wr_data   = {1'b1, {ORD_W{1'b0}}};
            cur_in        = '0;
            ram_rd_addr   = node_ff ^ NODE_W'(1);
            res_status_in = ST_OK;
            res_off_in    = alu_start[OFFSET_W-1:0];
            res_size_in   = alu_size[SIZE_W-1:0];
         end
         S_UP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = parent;
            ram_wr_data = {1'b0, alu_merged};
            node_in     = parent;
            ord_in      = ord_ff + ORD_W'(1);
            cur_in      = alu_merged;
            ram_rd_addr = parent ^ NODE_W'(1);
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               rsp_size_in   = res_size_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      zero_ff       <= zero_in;
      over_ff       <= over_in;
      k_ff          <= k_in;
      off_ff        <= off_in;
      node_ff       <= node_in;
      ord_ff        <= ord_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign req_stall          = state_ff != S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_off_ff;
   assign rsp_granted_size   = rsp_size_ff;

endmodule

// ===== rtl/core/bba_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Port-level assertions on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker
   import bba_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [OFFSET_W-1:0]   rsp_granted_offset,
   input logic [SIZE_W-1:0]     rsp_granted_size
);

   // out of reset: nothing to deliver, tree clearing holds off requests
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_stall)
      else $error("response or ready right after reset");

   // one request in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_granted_offset == '0 && rsp_granted_size == '0)
      else $error("error beat carries a block");

   // a granted block is a power of two and aligned to its size
   a_block_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && rsp_granted_size != '0 |->
         $onehot0(rsp_granted_size) &&
         ((SIZE_W'(rsp_granted_offset) & (rsp_granted_size - SIZE_W'(1))) == '0))
      else $error("granted block misaligned or not a power of two");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_granted_offset) && $stable(rsp_granted_size))
      else $error("stalled response beat changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
